// ===== hdl/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg: shared types and constants of the receive byte FIFO
// Buffer geometry, operation and status codes, terminator characters and the
// command and status bundles exchanged between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

   // Buffer geometry: the index and count widths follow from the depth.
   localparam int DEPTH = 256;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Fixed payload widths of the channels.
   localparam int BYTE_W  = 8;
   localparam int LEVEL_W = 9;

   // Characters of interest.
   localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
   localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_FLUSH = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // a request is taken this cycle
      logic finish;    // the stored byte of a pop or peek is available
      logic load_rsp;  // capture a result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic read_needed;  // the offered request reads the byte store
   } dp_stat_type;

endpackage : rbf_pkg

`default_nettype wire

// ===== hdl/rbf_req_if.sv =====
// ----------------------------------------------------------------------------
// rbf_req_if: request channel of the receive byte FIFO
// Valid/ready channel carrying the operation code and the byte to push.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbf_req_if;
   import rbf_pkg::*;

   logic                valid;
   logic                ready;
   func_type            func;
   logic [BYTE_W-1:0]   push_byte;

   modport source (output valid, output func, output push_byte, input ready);
   modport sink   (input valid, input func, input push_byte, output ready);

endinterface : rbf_req_if

`default_nettype wire

// ===== hdl/rbf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rbf_rsp_if: response channel of the receive byte FIFO
// Valid/ready channel carrying the read byte, status, fill level and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbf_rsp_if;
   import rbf_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   read_byte;
   status_type          status;
   logic [LEVEL_W-1:0]  fill_level;
   logic [LEVEL_W-1:0]  lines_pending;

   modport source (output valid, output read_byte, output status,
                   output fill_level, output lines_pending, input ready);
   modport sink   (input valid, input read_byte, input status,
                   input fill_level, input lines_pending, output ready);

endinterface : rbf_rsp_if

`default_nettype wire

// ===== hdl/rx_byte_fifo_with_line_count_core.sv =====
// ----------------------------------------------------------------------------
// rx_byte_fifo_with_line_count_core: receive byte FIFO with terminator count
// A circular byte buffer for a serial command receiver that also keeps the
// number of command terminators (';', CR, LF) waiting in it.
// ----------------------------------------------------------------------------
// Each request on req_chan carries an operation (push, pop, peek, flush) and
// a byte used only by push. Each request yields exactly one response on
// rsp_chan with the read byte (CR shown as LF, 0xFF when empty), a status
// (ok, full on push, empty on pop or peek), the fill level and the pending
// terminator count after the operation.
// Push, flush and pops or peeks of an empty buffer respond in the cycle after
// the request is taken and the next request can be taken in that same cycle,
// so they run at one request per cycle while responses are taken. A pop or
// peek of a nonempty buffer reads the registered read port of the byte store
// and waits in a read state, taking no new request, before it responds.
// Responses sit in an output register; a new request is taken while the
// waiting response leaves in the same cycle. If the receiver stalls, the
// response is held and requests are refused until it is taken.
// Reset empties the buffer and clears the terminator count at once; the
// byte store contents are not cleared, and are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_byte_fifo_with_line_count_core (
   input  wire logic  clock,
   input  wire logic  reset,
   rbf_req_if.sink    req_chan,
   rbf_rsp_if.source  rsp_chan
);
   import rbf_pkg::*;

   cmd_type     cmd;
   dp_stat_type dp_stat;

   // The controller sequences requests and owns the response valid flag.
   rbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   // The datapath holds the bytes, the counters and the response payload.
   rbf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_stat           (dp_stat),
      .req_func          (req_chan.func),
      .req_push_byte     (req_chan.push_byte),
      .rsp_read_byte     (rsp_chan.read_byte),
      .rsp_status        (rsp_chan.status),
      .rsp_fill_level    (rsp_chan.fill_level),
      .rsp_lines_pending (rsp_chan.lines_pending)
   );

endmodule : rx_byte_fifo_with_line_count_core

`default_nettype wire

// ===== hdl/rbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbf_ctrl: request sequencer of the receive byte FIFO
// Decides when a request is taken, waits in a read state for the byte store on
// reading operations and owns the valid flag of the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rbf_pkg::dp_stat_type dp_stat,
   output rbf_pkg::cmd_type          cmd
);
   import rbf_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // The response register can take a new result when it is empty or when
   // its current result leaves in this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && dp_stat.read_needed) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.finish   = 1'b0;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = out_free;
            cmd.accept   = req_valid && out_free;
            cmd.load_rsp = req_valid && out_free && !dp_stat.read_needed;
         end
         S_READ: begin
            cmd.finish   = 1'b1;
            cmd.load_rsp = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The read state is always followed by the idle state.
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_IDLE)
      else $error("read wait longer than one cycle");

   // No request is taken while a read is outstanding.
   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !req_ready)
      else $error("request taken during read wait");

   // The read wait always ends with a response on offer.
   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> rsp_valid_ff)
      else $error("read wait produced no response");

endmodule : rbf_ctrl

`default_nettype wire

// ===== hdl/rbf_datapath.sv =====
// ----------------------------------------------------------------------------
// rbf_datapath: storage and counters of the receive byte FIFO
// Byte store, ring indices, fill and terminator counters and the response
// register, all updated under the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rbf_pkg::cmd_type             cmd,
   output rbf_pkg::dp_stat_type              dp_stat,
   input  wire rbf_pkg::func_type            req_func,
   input  wire logic [rbf_pkg::BYTE_W-1:0]   req_push_byte,
   output logic [rbf_pkg::BYTE_W-1:0]        rsp_read_byte,
   output rbf_pkg::status_type               rsp_status,
   output logic [rbf_pkg::LEVEL_W-1:0]       rsp_fill_level,
   output logic [rbf_pkg::LEVEL_W-1:0]       rsp_lines_pending
);
   import rbf_pkg::*;

   logic [BYTE_W-1:0]  mem_ff [DEPTH];
   logic [BYTE_W-1:0]  rd_data_ff;
   func_type           op_ff;

   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic [CNT_W-1:0]   term_ff, term_in;

   logic [BYTE_W-1:0]  byte_ff, byte_in;
   status_type         status_ff, status_in;
   logic [LEVEL_W-1:0] fill_ff, lines_ff;

   logic               full, empty;
   logic               push_is_term;
   logic               store_write;
   logic [BYTE_W-1:0]  shown;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   assign full  = (held_ff == CNT_W'(DEPTH));
   assign empty = (held_ff == '0);
   assign push_is_term = (req_push_byte == CH_SEMI) || (req_push_byte == CH_CR) ||
                         (req_push_byte == CH_LF);
   assign shown = (rd_data_ff == CH_CR) ? CH_LF : rd_data_ff;
   assign store_write = cmd.accept && (req_func == OP_PUSH) && !full;

   assign dp_stat.read_needed = ((req_func == OP_POP) || (req_func == OP_PEEK)) && !empty;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      held_in   = held_ff;
      term_in   = term_ff;
      byte_in   = ZERO_BYTE;
      status_in = ST_OK;
      if (cmd.accept) begin
         case (req_func)
            OP_PUSH: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_idx_in = next_slot(wr_idx_ff);
                  held_in   = held_ff + CNT_W'(1);
                  if (push_is_term) begin
                     term_in = term_ff + CNT_W'(1);
                  end
               end
            end
            OP_POP: begin
               if (empty) begin
                  term_in   = '0;
                  byte_in   = EMPTY_BYTE;
                  status_in = ST_EMPTY;
               end else begin
                  rd_idx_in = next_slot(rd_idx_ff);
                  held_in   = held_ff - CNT_W'(1);
               end
            end
            OP_PEEK: begin
               if (empty) begin
                  byte_in   = EMPTY_BYTE;
                  status_in = ST_EMPTY;
               end
            end
            OP_FLUSH: begin
               wr_idx_in = '0;
               rd_idx_in = '0;
               held_in   = '0;
               term_in   = '0;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
      if (cmd.finish) begin
         byte_in = shown;
         if ((op_ff == OP_POP) && ((shown == CH_SEMI) || (shown == CH_LF)) &&
             (term_ff != '0)) begin
            term_in = term_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_write) begin
         mem_ff[wr_idx_ff] <= req_push_byte;
      end
      if (cmd.accept) begin
         rd_data_ff <= mem_ff[rd_idx_ff];
         op_ff      <= req_func;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         held_ff   <= '0;
         term_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         held_ff   <= held_in;
         term_ff   <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         byte_ff   <= byte_in;
         status_ff <= status_in;
         fill_ff   <= LEVEL_W'(held_in);
         lines_ff  <= LEVEL_W'(term_in);
      end
   end

   assign rsp_read_byte     = byte_ff;
   assign rsp_status        = status_ff;
   assign rsp_fill_level    = fill_ff;
   assign rsp_lines_pending = lines_ff;

   // The fill count never passes the buffer depth.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   // Every counted terminator is still held in the buffer. During the read
   // wait of a pop the fill count has already dropped while the terminator
   // count is only lowered at the end of the wait, so one extra is allowed.
   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      term_ff <= held_ff + CNT_W'(cmd.finish))
      else $error("terminator count above fill count");

   // A flush leaves the buffer empty with no pending terminators.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_func == OP_FLUSH |=> held_ff == '0 && term_ff == '0)
      else $error("flush did not clear the buffer");

endmodule : rbf_datapath

`default_nettype wire
